FILE: rtl/core/state_space_euler_step_top_macros.svh
// Assertion macros for the state-space Euler step block.
// Included by the top level; expects clk and rst_n in scope.
`ifndef STATE_SPACE_EULER_STEP_TOP_MACROS_SVH
`define STATE_SPACE_EULER_STEP_TOP_MACROS_SVH

`ifndef SYNTHESIS
// property that must hold at every clock edge out of reset
`define SSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// consequence that must hold in the cycle after the antecedent
`define SSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SSE_ASSERT(lbl, prop, msg)
`define SSE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/core/sse_pkg.sv
// Shared types, constants and the microcode program of the state-space Euler step.
// No dependencies; used by sse_seq, sse_dp and the top level.
package sse_pkg;

  // system size and field widths
  localparam int SYSTEM_ORDER = 4;
  localparam int IDX_W        = (SYSTEM_ORDER > 1) ? $clog2(SYSTEM_ORDER) : 1;
  localparam int DATA_W       = 32;              // Q16.16 samples
  localparam int COEF_W       = 32;              // Q8.24 coefficients
  localparam int STATE_W      = 48;              // Q16.32 state
  localparam int SPLIT        = 24;              // state split point for the multiplier
  localparam int D_W          = 58;              // Euler drive term, Q.32
  localparam int MUL_B_W      = D_W - SPLIT;     // multiplier B operand
  localparam int MUL_P_W      = COEF_W + MUL_B_W;
  localparam int ACC_W        = 60;              // accumulators and finish result
  localparam int SH_OUT       = 16;              // Q.32 sum -> Q16.16 output
  localparam int SH_INC       = 8;               // Q.40 step term -> Q.32 increment
  localparam int U_SHIFT      = 16;              // Q16.16 input -> Q.32

  // configuration register map
  localparam int COEF_SLOTS   = 4;
  localparam int COEF_IDX_W   = 2;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DEN_BASE = 0;
  localparam int CFG_NUM_BASE = CFG_DEN_BASE + COEF_SLOTS;

  // Euler step h = 0.001 in Q0.32
  localparam logic signed [COEF_W-1:0] STEP_Q32 = 32'sd4294967;

  // program layout
  localparam int UC_DIFF  = (3 * SYSTEM_ORDER > 2 * SYSTEM_ORDER + 4) ?
                            3 * SYSTEM_ORDER : 2 * SYSTEM_ORDER + 4;
  localparam int UC_DEPTH = UC_DIFF + 5;
  localparam int PC_W     = $clog2(UC_DEPTH);

  typedef enum logic [1:0] {
    COND_NEXT,
    COND_JUMP,
    COND_IN_VALID,
    COND_OUT_FREE
  } cond_t;

  typedef enum logic [1:0] {
    A_NUM,
    A_DEN,
    A_STEP
  } a_sel_t;

  typedef enum logic [1:0] {
    RND_24,
    RND_32,
    RND_40
  } rnd_t;

  // one control word
  typedef struct packed {
    logic            mul_en;   // issue a multiply pair
    a_sel_t          a_sel;    // coefficient operand
    logic            b_diff;   // B operand from drive term instead of state
    logic [IDX_W-1:0] idx;     // state / coefficient index
    logic            acc_clr;  // product starts a new sum
    logic            fin;      // round accumulators into the finish register
    rnd_t            rnd;      // rounding point for fin
    logic            wr_y;     // capture output sample
    logic            wr_d;     // capture drive term
    logic            wr_x;     // update state element idx
    logic            push;     // hand output sample to the result register
    cond_t           cond;     // sequencing
    logic [PC_W-1:0] target;   // jump target
  } ctl_t;

  // program table: control word for each step
  function automatic ctl_t uc_word(input logic [PC_W-1:0] pc);
    ctl_t w;
    int   s;
    int   n;
    s = int'(pc);
    n = SYSTEM_ORDER;
    w = '0;
    w.cond   = COND_NEXT;
    w.a_sel  = A_NUM;
    w.rnd    = RND_24;
    w.target = '0;
    // wait for a request
    if (s == 0) begin
      w.cond   = COND_IN_VALID;
      w.target = PC_W'(1);
    end
    // output sum b.x
    if (s >= 1 && s <= n) begin
      w.mul_en  = 1'b1;
      w.a_sel   = A_NUM;
      w.idx     = IDX_W'(s - 1);
      w.acc_clr = (s == 1);
    end
    // feedback sum a.x
    if (s >= n + 1 && s <= 2 * n) begin
      w.mul_en  = 1'b1;
      w.a_sel   = A_DEN;
      w.idx     = IDX_W'(s - n - 1);
      w.acc_clr = (s == n + 1);
    end
    // h * x[k+1] for the chained states
    if (s >= 2 * n + 1 && s <= 3 * n - 1) begin
      w.mul_en  = 1'b1;
      w.a_sel   = A_STEP;
      w.idx     = IDX_W'(s - 2 * n);
      w.acc_clr = 1'b1;
    end
    // h * d for the last state
    if (s == UC_DIFF) begin
      w.mul_en  = 1'b1;
      w.a_sel   = A_STEP;
      w.b_diff  = 1'b1;
      w.acc_clr = 1'b1;
    end
    // finish steps
    if (s == n + 2) begin
      w.fin = 1'b1;
      w.rnd = RND_40;
    end
    if (s == 2 * n + 2) begin
      w.fin = 1'b1;
      w.rnd = RND_24;
    end
    if ((s >= 2 * n + 3 && s <= 3 * n + 1) || s == UC_DIFF + 2) begin
      w.fin = 1'b1;
      w.rnd = RND_32;
    end
    // write-backs
    if (s == n + 3)
      w.wr_y = 1'b1;
    if (s == 2 * n + 3)
      w.wr_d = 1'b1;
    if (s >= 2 * n + 4 && s <= 3 * n + 2) begin
      w.wr_x = 1'b1;
      w.idx  = IDX_W'(s - 2 * n - 4);
    end
    if (s == UC_DIFF + 3) begin
      w.wr_x = 1'b1;
      w.idx  = IDX_W'(n - 1);
    end
    // deliver result and return to idle
    if (s == UC_DIFF + 4) begin
      w.push   = 1'b1;
      w.cond   = COND_OUT_FREE;
      w.target = '0;
    end
    if (s >= UC_DEPTH) begin
      w.cond   = COND_JUMP;
      w.target = '0;
    end
    return w;
  endfunction

endpackage

FILE: rtl/core/sse_seq.sv
// Microcode sequencer: step counter, program table lookup and conditional jumps.
// Depends on sse_pkg.
module sse_seq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          out_free,
  output sse_pkg::ctl_t ctl,
  output logic          in_stall
);
  import sse_pkg::*;

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;

  // current control word
  always_comb begin
    ctl = uc_word(pc_r);
  end

  // only the idle step takes a request
  assign in_stall = (ctl.cond != COND_IN_VALID);

  // next step
  always_comb begin
    case (ctl.cond)
      COND_NEXT:     pc_nxt = pc_r + PC_W'(1);
      COND_JUMP:     pc_nxt = ctl.target;
      COND_IN_VALID: pc_nxt = in_valid ? ctl.target : pc_r;
      COND_OUT_FREE: pc_nxt = out_free ? ctl.target : pc_r;
      default:       pc_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

FILE: rtl/core/sse_dp.sv
// Datapath: coefficient and state registers, dual multiplier, accumulators,
// rounding, saturation and the result register. Depends on sse_pkg.
module sse_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  sse_pkg::ctl_t                         ctl,
  input  logic                                  cfg_we,
  input  logic [sse_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic signed [sse_pkg::COEF_W-1:0]     cfg_wdata,
  input  logic                                  in_accept,
  input  logic signed [sse_pkg::DATA_W-1:0]     in_drive_sample,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [sse_pkg::DATA_W-1:0]     out_response_sample,
  output logic                                  out_free
);
  import sse_pkg::*;

  function automatic logic signed [DATA_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi_lim;
    logic signed [ACC_W-1:0] lo_lim;
    hi_lim = {{(ACC_W - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}};
    lo_lim = ~hi_lim;
    if (v > hi_lim)
      return hi_lim[DATA_W-1:0];
    else if (v < lo_lim)
      return lo_lim[DATA_W-1:0];
    return v[DATA_W-1:0];
  endfunction

  function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi_lim;
    logic signed [ACC_W-1:0] lo_lim;
    hi_lim = {{(ACC_W - STATE_W + 1){1'b0}}, {(STATE_W - 1){1'b1}}};
    lo_lim = ~hi_lim;
    if (v > hi_lim)
      return hi_lim[STATE_W-1:0];
    else if (v < lo_lim)
      return lo_lim[STATE_W-1:0];
    return v[STATE_W-1:0];
  endfunction

  logic signed [COEF_W-1:0]  den_r [COEF_SLOTS];
  logic signed [COEF_W-1:0]  num_r [COEF_SLOTS];
  logic signed [STATE_W-1:0] x_r   [SYSTEM_ORDER];
  logic signed [DATA_W-1:0]  u_r;
  logic signed [D_W-1:0]     d_r;
  logic signed [ACC_W-1:0]   prod_hi_r, prod_lo_r;
  logic signed [ACC_W-1:0]   acc_hi_r, acc_lo_r;
  logic                      acc_en_r, acc_ld_r;
  logic signed [ACC_W-1:0]   t_r;
  logic signed [DATA_W-1:0]  y_hold_r;
  logic                      out_valid_r;
  logic signed [DATA_W-1:0]  out_data_r;

  logic [COEF_IDX_W-1:0]     coef_idx;
  logic signed [STATE_W-1:0] x_sel;
  logic signed [COEF_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0] mul_bh, mul_bl;
  logic signed [MUL_P_W-1:0] p_hi, p_lo;
  logic signed [ACC_W-1:0]   rnd_c, lo_rnd, t_nxt;
  logic signed [ACC_W-1:0]   y_full, d_full, inc, x_sum, u_ext, x_ext;
  logic                      push;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < COEF_SLOTS; i++) begin
        den_r[i] <= '0;
        num_r[i] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index < CFG_IDX_W'(CFG_NUM_BASE)) begin
        den_r[cfg_index[COEF_IDX_W-1:0]] <= cfg_wdata;
      end else begin
        num_r[cfg_index[COEF_IDX_W-1:0]] <= cfg_wdata;
      end
    end
  end

  // input sample
  always_ff @(posedge clk) begin
    if (in_accept) begin
      u_r <= in_drive_sample;
    end
  end

  // operand select
  assign coef_idx = COEF_IDX_W'(ctl.idx);
  assign x_sel    = x_r[ctl.idx];

  always_comb begin
    case (ctl.a_sel)
      A_NUM:   mul_a = num_r[coef_idx];
      A_DEN:   mul_a = den_r[coef_idx];
      A_STEP:  mul_a = STEP_Q32;
      default: mul_a = '0;
    endcase
    if (ctl.b_diff) begin
      mul_bh = d_r[D_W-1:SPLIT];
      mul_bl = {{(MUL_B_W - SPLIT){1'b0}}, d_r[SPLIT-1:0]};
    end else begin
      mul_bh = {{(MUL_B_W - (STATE_W - SPLIT)){x_sel[STATE_W-1]}}, x_sel[STATE_W-1:SPLIT]};
      mul_bl = {{(MUL_B_W - SPLIT){1'b0}}, x_sel[SPLIT-1:0]};
    end
  end

  // high and low partial products
  assign p_hi = mul_a * mul_bh;
  assign p_lo = mul_a * mul_bl;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_hi_r <= p_hi[ACC_W-1:0];
      prod_lo_r <= p_lo[ACC_W-1:0];
    end
  end

  // accumulate in the cycle after the multiply, from the product registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_en_r <= 1'b0;
      acc_ld_r <= 1'b0;
    end else begin
      acc_en_r <= ctl.mul_en;
      acc_ld_r <= ctl.acc_clr;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_en_r) begin
      acc_hi_r <= acc_ld_r ? prod_hi_r : acc_hi_r + prod_hi_r;
      acc_lo_r <= acc_ld_r ? prod_lo_r : acc_lo_r + prod_lo_r;
    end
  end

  // round half up: fold low sum into high sum
  always_comb begin
    rnd_c = '0;
    case (ctl.rnd)
      RND_24:  rnd_c[SPLIT-1] = 1'b1;
      RND_32:  rnd_c[SPLIT-1+SH_INC] = 1'b1;
      RND_40:  rnd_c[SPLIT-1+SH_OUT] = 1'b1;
      default: rnd_c = '0;
    endcase
  end

  assign lo_rnd = acc_lo_r + rnd_c;
  assign t_nxt  = acc_hi_r + (lo_rnd >>> SPLIT);

  always_ff @(posedge clk) begin
    if (ctl.fin) begin
      t_r <= t_nxt;
    end
  end

  // output sample, drive term, state increment
  assign y_full = t_r >>> SH_OUT;
  assign u_ext  = {{(ACC_W - DATA_W){u_r[DATA_W-1]}}, u_r};
  assign d_full = (u_ext <<< U_SHIFT) - t_r;
  assign inc    = t_r >>> SH_INC;
  assign x_ext  = {{(ACC_W - STATE_W){x_sel[STATE_W-1]}}, x_sel};
  assign x_sum  = x_ext + inc;

  always_ff @(posedge clk) begin
    if (ctl.wr_y) begin
      y_hold_r <= sat_out(y_full);
    end
    if (ctl.wr_d) begin
      d_r <= d_full[D_W-1:0];
    end
  end

  // state vector, updated in place in ascending order
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SYSTEM_ORDER; i++) begin
        x_r[i] <= '0;
      end
    end else if (ctl.wr_x) begin
      x_r[ctl.idx] <= sat_state(x_sum);
    end
  end

  // result register
  assign out_free = !out_valid_r || !out_stall;
  assign push     = ctl.push && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_data_r <= y_hold_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_response_sample = out_data_r;

endmodule

FILE: rtl/core/state_space_euler_step_top.sv
// Top level of the fourth-order state-space simulator with forward Euler update.
// Depends on sse_pkg, sse_seq, sse_dp and state_space_euler_step_top_macros.svh.
//
// Usage:
//   Configuration: cfg_we with cfg_index 0..3 writes a0..a3, 4..7 writes b0..b3
//   (signed Q8.24). Write only while the block is idle.
//   Input: one request per sample on in_valid / in_stall carrying in_drive_sample
//   (Q16.16). in_stall is low only while the sequencer sits at its idle step.
//   Output: one request per sample on out_valid / out_stall carrying
//   out_response_sample = b.x of the state before the update, Q16.16, saturated.
//   Timing: a program of max(3N, 2N+4) + 5 steps runs per sample; its length is
//   set by the two partial products per term going through one pair of 32x34
//   multipliers. The result register loads, and out_valid rises, when the
//   delivery step at the end of the program finds the result register free.
//   Stall: a held result register keeps the sequencer at its last step, so
//   the next request waits until the previous result is taken or can be.
//   Reset: coefficients and state clear to zero, no result is pending.
`include "state_space_euler_step_top_macros.svh"

module state_space_euler_step_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [sse_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic signed [sse_pkg::COEF_W-1:0]   cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [sse_pkg::DATA_W-1:0]   in_drive_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [sse_pkg::DATA_W-1:0]   out_response_sample
);
  import sse_pkg::*;

  ctl_t ctl;
  logic out_free;
  logic in_accept;

  assign in_accept = in_valid && !in_stall;

  // program sequencer
  sse_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .ctl      (ctl),
    .in_stall (in_stall)
  );

  // arithmetic and storage
  sse_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .ctl                 (ctl),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_accept           (in_accept),
    .in_drive_sample     (in_drive_sample),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_response_sample (out_response_sample),
    .out_free            (out_free)
  );

  // a taken request starts the program, which then blocks new requests
  `SSE_ASSERT_NEXT(a_accept_runs, in_accept, in_stall, "request taken but sequencer still idle")
  // a delivered result always shows on the output
  `SSE_ASSERT_NEXT(a_push_shows, ctl.push && out_free, out_valid, "pushed result not valid")
  // the delivery step may repeat, so it must not start products or touch state
  `SSE_ASSERT(a_push_step_quiet, ctl.push |-> (ctl.cond == COND_OUT_FREE) && !ctl.mul_en && !ctl.wr_x, "delivery step has side effects")

endmodule
